// ----- sv/afx_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the Q16.16 affine transform engine.
// Used by the controller, the datapath, the iterative unit and the top level.
package afx_pkg;

   localparam int WORD_BITS = 32;
   localparam int MAT_DEPTH = 12;
   localparam int IDX_BITS  = 4;

   typedef logic signed [WORD_BITS-1:0]   word_type;
   typedef logic signed [2*WORD_BITS-1:0] dword_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   typedef enum logic [2:0] {
      OP_IDENTITY  = 3'd0,
      OP_SCALE     = 3'd1,
      OP_SHIFT     = 3'd2,
      OP_ROT_X     = 3'd3,
      OP_ROT_Z     = 3'd4,
      OP_VIEW      = 3'd5,
      OP_TRANSFORM = 3'd6,
      OP_NONE      = 3'd7
   } op_type;

   typedef struct packed {
      logic [2:0] operation;
      word_type   scale_factor;
      word_type   cos_value;
      word_type   sin_value;
      word_type   x_coord;
      word_type   y_coord;
      word_type   z_coord;
   } req_type;

   typedef struct packed {
      word_type out_x;
      word_type out_y;
      word_type out_z;
      logic     saturated;
   } rsp_type;

   typedef enum logic [2:0] {
      OPN_COS, OPN_SIN, OPN_RDA, OPN_RDB, OPN_SF, OPN_PX, OPN_PY, OPN_PZ
   } opnd_type;

   typedef enum logic [1:0] {ACC_NONE, ACC_ADD, ACC_SUB} acc_op_type;
   typedef enum logic [1:0] {LHS_T, LHS_ACC, LHS_RDA} lhs_type;
   typedef enum logic [2:0] {RHS_PROD, RHS_RDA, RHS_PX, RHS_PY, RHS_PZ} rhs_type;
   typedef enum logic {WR_ACC, WR_PROD} wr_src_type;
   typedef enum logic [2:0] {LD_NONE, LD_V, LD_COS_Q, LD_SIN_Q, LD_XROT} ld_type;
   typedef enum logic {IT_SQRT, IT_DIV} it_mode_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_SCL_RD, S_SCL_MUL, S_SCL_WR,
      S_SFT_RD, S_SFT_SUB, S_SFT_WR,
      S_ROT_RD, S_ROT_M0, S_ROT_M1, S_ROT_M2, S_ROT_M3, S_ROT_A1, S_ROT_W1,
      S_TR_RD0, S_TR_MR1, S_TR_MR2, S_TR_MR3, S_TR_A2, S_TR_A3, S_TR_OUT,
      S_VW_SQX, S_VW_SQY, S_VW_SUM, S_VW_GO, S_VW_ROOT, S_VW_CHK,
      S_VW_DIVY, S_VW_DIVX, S_VW_XSET
   } state_type;

   typedef struct packed {
      logic                take;
      logic                clear;
      logic                rd_en;
      logic [IDX_BITS-1:0] rd_addr_a;
      logic [IDX_BITS-1:0] rd_addr_b;
      logic                mul_en;
      logic                mul_chk;
      opnd_type            mul_a;
      opnd_type            mul_b;
      logic                t_load;
      acc_op_type          acc_op;
      lhs_type             acc_lhs;
      rhs_type             acc_rhs;
      logic                wr_en;
      logic [IDX_BITS-1:0] wr_addr;
      wr_src_type          wr_src;
      logic                out_load;
      logic [1:0]          out_row;
      logic                rsp_load;
      logic                sq_first;
      logic                sq_add;
      logic                it_start;
      it_mode_type         it_mode;
      logic                div_x;
      ld_type              ld;
   } cmd_type;

   typedef struct packed {
      logic it_done;
      logic v_zero;
      logic rsp_free;
   } sts_type;

endpackage

// ----- sv/afx_iter.sv -----
`timescale 1ns / 1ps
// Bit-serial unit for the view operation: integer square root and fractional divide.
// One result bit per cycle; depends on afx_pkg.
module afx_iter
   import afx_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  it_mode_type                     mode,
   input  logic [2*WORD_BITS-1:0]          rad,
   input  logic [WORD_BITS-1:0]            num,
   input  logic [WORD_BITS-1:0]            den,
   output logic                            done,
   output logic [WORD_BITS-1:0]            root_out,
   output logic [WORD_BITS+FRAC_BITS-1:0]  quot_out
);

   localparam int QW = WORD_BITS + FRAC_BITS;
   localparam int CW = $clog2(QW + 1);

   logic                   busy_ff, done_ff;
   logic [CW-1:0]          cnt_ff;
   it_mode_type            mode_ff;
   logic [2*WORD_BITS-1:0] rad_ff;
   logic [WORD_BITS+1:0]   srem_ff;
   logic [WORD_BITS-1:0]   root_ff;
   logic [QW-1:0]          dvd_ff, quo_ff;
   logic [WORD_BITS-1:0]   drem_ff, den_ff;

   logic [WORD_BITS+3:0]   s_tmp, s_test, s_diff;
   logic                   s_ge;
   logic [WORD_BITS:0]     d_tmp;
   logic                   d_ge;
   logic                   last;

   always_comb begin
      s_tmp  = {srem_ff, rad_ff[2*WORD_BITS-1 -: 2]};
      s_test = {2'b00, root_ff, 2'b01};
      s_diff = s_tmp - s_test;
      s_ge   = s_tmp >= s_test;
      d_tmp  = {drem_ff, dvd_ff[QW-1]};
      d_ge   = d_tmp >= {1'b0, den_ff};
      last   = (mode_ff == IT_SQRT) ? (cnt_ff == CW'(WORD_BITS - 1)) : (cnt_ff == CW'(QW - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && last) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff  <= '0;
         mode_ff <= mode;
         rad_ff  <= rad;
         srem_ff <= '0;
         root_ff <= '0;
         dvd_ff  <= {num, {FRAC_BITS{1'b0}}};
         quo_ff  <= '0;
         drem_ff <= '0;
         den_ff  <= den;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + CW'(1);
         if (mode_ff == IT_SQRT) begin
            rad_ff  <= rad_ff << 2;
            srem_ff <= s_ge ? s_diff[WORD_BITS+1:0] : s_tmp[WORD_BITS+1:0];
            root_ff <= {root_ff[WORD_BITS-2:0], s_ge};
         end else begin
            dvd_ff  <= dvd_ff << 1;
            drem_ff <= d_ge ? WORD_BITS'(d_tmp - {1'b0, den_ff}) : d_tmp[WORD_BITS-1:0];
            quo_ff  <= {quo_ff[QW-2:0], d_ge};
         end
      end
   end

   assign done     = done_ff;
   assign root_out = root_ff;
   assign quot_out = quo_ff;

endmodule

// ----- sv/afx_dp.sv -----
`timescale 1ns / 1ps
// Datapath: matrix store, shared multiplier, saturating adder and result register.
// Driven by afx_ctrl commands; uses afx_pkg and afx_iter.
module afx_dp
   import afx_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   output sts_type sts,
   input  req_type req_data,
   input  logic    rsp_stall,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int QW = WORD_BITS + FRAC_BITS;
   localparam word_type ONE = word_type'(1) << FRAC_BITS;

   word_type               mem_ff [MAT_DEPTH];
   logic [MAT_DEPTH-1:0]   vld_ff;
   word_type               rda_ff, rdb_ff;
   word_type               sf_ff, cos_ff, sin_ff, px_ff, py_ff, pz_ff;
   word_type               prod_ff, t_ff, acc_ff, v_ff;
   dword_type              full_ff;
   logic [2*WORD_BITS-1:0] sum_ff;
   word_type               res_ff [3];
   logic                   ovf_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;

   word_type               mul_a_val, mul_b_val, lhs_val, rhs_val, wr_val, mul_sat;
   dword_type              mul_full, mul_shr;
   logic                   mul_ovf;
   logic [WORD_BITS:0]     acc_res, ld_res;
   logic                   acc_en, clip_any, ld_clip;
   logic                   it_done;
   logic [WORD_BITS-1:0]   it_root, div_num, px_mag, py_mag;
   logic [QW-1:0]          it_quot;

   function automatic word_type ident(logic [IDX_BITS-1:0] a);
      return (a == IDX_BITS'(0) || a == IDX_BITS'(5) || a == IDX_BITS'(10)) ? ONE : '0;
   endfunction

   function automatic logic [WORD_BITS:0] sat_op(word_type a, word_type b, logic sub);
      logic signed [WORD_BITS:0] s;
      s = sub ? ((WORD_BITS+1)'(a) - (WORD_BITS+1)'(b))
              : ((WORD_BITS+1)'(a) + (WORD_BITS+1)'(b));
      if (s[WORD_BITS] != s[WORD_BITS-1]) begin
         return {1'b1, s[WORD_BITS] ? WORD_MIN : WORD_MAX};
      end
      return {1'b0, s[WORD_BITS-1:0]};
   endfunction

   function automatic logic [WORD_BITS:0] quot_trig(logic [QW-1:0] q, logic neg);
      logic     clip;
      word_type qv;
      clip = 1'b0;
      if (!neg) begin
         if (q > QW'(WORD_MAX)) begin
            clip = 1'b1;
            qv   = WORD_MAX;
         end else begin
            qv = word_type'(q[WORD_BITS-1:0]);
         end
      end else begin
         if (q > (QW'(1) << (WORD_BITS - 1))) begin
            clip = 1'b1;
            qv   = WORD_MIN;
         end else begin
            qv = -word_type'(q[WORD_BITS-1:0]);
         end
      end
      if (qv == WORD_MIN) begin
         return {1'b1, WORD_MAX};
      end
      return {clip, -qv};
   endfunction

   always_comb begin
      case (cmd.mul_a)
         OPN_COS: mul_a_val = cos_ff;
         OPN_SIN: mul_a_val = sin_ff;
         OPN_RDA: mul_a_val = rda_ff;
         OPN_RDB: mul_a_val = rdb_ff;
         OPN_SF:  mul_a_val = sf_ff;
         OPN_PX:  mul_a_val = px_ff;
         OPN_PY:  mul_a_val = py_ff;
         default: mul_a_val = pz_ff;
      endcase
      case (cmd.mul_b)
         OPN_COS: mul_b_val = cos_ff;
         OPN_SIN: mul_b_val = sin_ff;
         OPN_RDA: mul_b_val = rda_ff;
         OPN_RDB: mul_b_val = rdb_ff;
         OPN_SF:  mul_b_val = sf_ff;
         OPN_PX:  mul_b_val = px_ff;
         OPN_PY:  mul_b_val = py_ff;
         default: mul_b_val = pz_ff;
      endcase
      case (cmd.acc_lhs)
         LHS_T:   lhs_val = t_ff;
         LHS_ACC: lhs_val = acc_ff;
         default: lhs_val = rda_ff;
      endcase
      case (cmd.acc_rhs)
         RHS_PROD: rhs_val = prod_ff;
         RHS_RDA:  rhs_val = rda_ff;
         RHS_PX:   rhs_val = px_ff;
         RHS_PY:   rhs_val = py_ff;
         default:  rhs_val = pz_ff;
      endcase
   end

   always_comb begin
      mul_full = dword_type'(mul_a_val) * dword_type'(mul_b_val);
      mul_shr  = mul_full >>> FRAC_BITS;
      mul_ovf  = !((&mul_shr[2*WORD_BITS-1:WORD_BITS-1]) ||
                   !(|mul_shr[2*WORD_BITS-1:WORD_BITS-1]));
      mul_sat  = mul_ovf ? (mul_shr[2*WORD_BITS-1] ? WORD_MIN : WORD_MAX)
                         : mul_shr[WORD_BITS-1:0];
      acc_en   = cmd.acc_op != ACC_NONE;
      acc_res  = sat_op(lhs_val, rhs_val, cmd.acc_op == ACC_SUB);
      wr_val   = (cmd.wr_src == WR_PROD) ? prod_ff : acc_ff;
      px_mag   = px_ff[WORD_BITS-1] ? WORD_BITS'(-px_ff) : WORD_BITS'(px_ff);
      py_mag   = py_ff[WORD_BITS-1] ? WORD_BITS'(-py_ff) : WORD_BITS'(py_ff);
      div_num  = cmd.div_x ? px_mag : py_mag;
      ld_res   = '0;
      ld_clip  = 1'b0;
      case (cmd.ld)
         LD_V: begin
            ld_clip = it_root[WORD_BITS-1];
         end
         LD_COS_Q: begin
            ld_res  = quot_trig(it_quot, py_ff[WORD_BITS-1]);
            ld_clip = ld_res[WORD_BITS];
         end
         LD_SIN_Q: begin
            ld_res  = quot_trig(it_quot, px_ff[WORD_BITS-1]);
            ld_clip = ld_res[WORD_BITS];
         end
         default: ld_clip = 1'b0;
      endcase
      clip_any = (cmd.mul_en && cmd.mul_chk && mul_ovf) ||
                 (acc_en && acc_res[WORD_BITS]) || ld_clip;
   end

   afx_iter #(.FRAC_BITS(FRAC_BITS)) u_iter (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.it_start),
      .mode     (cmd.it_mode),
      .rad      (sum_ff),
      .num      (div_num),
      .den      (WORD_BITS'(v_ff)),
      .done     (it_done),
      .root_out (it_root),
      .quot_out (it_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (cmd.clear) begin
         vld_ff <= '0;
      end else if (cmd.wr_en) begin
         vld_ff[cmd.wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[cmd.wr_addr] <= wr_val;
      end
      if (cmd.rd_en) begin
         rda_ff <= vld_ff[cmd.rd_addr_a] ? mem_ff[cmd.rd_addr_a] : ident(cmd.rd_addr_a);
         rdb_ff <= vld_ff[cmd.rd_addr_b] ? mem_ff[cmd.rd_addr_b] : ident(cmd.rd_addr_b);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         sf_ff  <= req_data.scale_factor;
         cos_ff <= req_data.cos_value;
         sin_ff <= req_data.sin_value;
         px_ff  <= req_data.x_coord;
         py_ff  <= req_data.y_coord;
         pz_ff  <= req_data.z_coord;
      end else begin
         case (cmd.ld)
            LD_V:     v_ff   <= it_root[WORD_BITS-1] ? WORD_MAX : word_type'(it_root);
            LD_COS_Q: cos_ff <= ld_res[WORD_BITS-1:0];
            LD_SIN_Q: sin_ff <= ld_res[WORD_BITS-1:0];
            LD_XROT: begin
               cos_ff <= pz_ff;
               sin_ff <= -v_ff;
            end
            default: ;
         endcase
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_sat;
         full_ff <= mul_full;
      end
      if (cmd.t_load) begin
         t_ff <= prod_ff;
      end
      if (acc_en) begin
         acc_ff <= acc_res[WORD_BITS-1:0];
      end
      if (cmd.out_load) begin
         res_ff[cmd.out_row] <= acc_res[WORD_BITS-1:0];
      end
      if (cmd.sq_first) begin
         sum_ff <= full_ff;
      end else if (cmd.sq_add) begin
         sum_ff <= sum_ff + full_ff;
      end
      if (cmd.rsp_load) begin
         rsp_ff.out_x     <= res_ff[0];
         rsp_ff.out_y     <= res_ff[1];
         rsp_ff.out_z     <= res_ff[2];
         rsp_ff.saturated <= ovf_ff || clip_any;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ovf_ff <= cmd.rsp_load ? 1'b0 : (ovf_ff || clip_any);
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.it_done  = it_done;
   assign sts.v_zero   = v_ff == '0;
   assign sts.rsp_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

endmodule

// ----- sv/afx_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine: sequences each request into datapath commands.
// Uses afx_pkg; pairs with afx_dp.
module afx_ctrl
   import afx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [2:0] req_op,
   output logic       req_stall,
   input  sts_type    sts,
   output cmd_type    cmd
);

   state_type  state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       pair_ff, pair_in;
   logic       view_ff, view_in;
   logic [1:0] row_a, row_b, col;
   logic       accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         pair_ff  <= 1'b0;
         view_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pair_ff  <= pair_in;
         view_ff  <= view_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign col       = cnt_ff[1:0];
   assign row_a     = {1'b0, pair_ff};
   assign row_b     = pair_ff ? 2'd2 : 2'd1;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      pair_in  = pair_ff;
      view_in  = view_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.take = accept;
            if (accept) begin
               cnt_in  = '0;
               view_in = 1'b0;
               case (op_type'(req_op))
                  OP_IDENTITY:  cmd.clear = 1'b1;
                  OP_SCALE:     state_in = S_SCL_RD;
                  OP_SHIFT:     state_in = S_SFT_RD;
                  OP_ROT_X: begin
                     pair_in  = 1'b1;
                     state_in = S_ROT_RD;
                  end
                  OP_ROT_Z: begin
                     pair_in  = 1'b0;
                     state_in = S_ROT_RD;
                  end
                  OP_VIEW: begin
                     view_in  = 1'b1;
                     state_in = S_VW_SQX;
                  end
                  OP_TRANSFORM: state_in = S_TR_RD0;
                  default:      state_in = S_IDLE;
               endcase
            end
         end
         S_SCL_RD: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_addr_a = cnt_ff;
            cmd.rd_addr_b = cnt_ff;
            state_in      = S_SCL_MUL;
         end
         S_SCL_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_chk = 1'b1;
            cmd.mul_a   = OPN_RDA;
            cmd.mul_b   = OPN_SF;
            state_in    = S_SCL_WR;
         end
         S_SCL_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = cnt_ff;
            cmd.wr_src  = WR_PROD;
            if (cnt_ff == 4'(MAT_DEPTH - 1)) begin
               state_in = S_IDLE;
            end else begin
               cnt_in   = cnt_ff + 4'd1;
               state_in = S_SCL_RD;
            end
         end
         S_SFT_RD: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_addr_a = {col, 2'd3};
            cmd.rd_addr_b = {col, 2'd3};
            state_in      = S_SFT_SUB;
         end
         S_SFT_SUB: begin
            cmd.acc_op  = ACC_SUB;
            cmd.acc_lhs = LHS_RDA;
            case (col)
               2'd0:    cmd.acc_rhs = RHS_PX;
               2'd1:    cmd.acc_rhs = RHS_PY;
               default: cmd.acc_rhs = RHS_PZ;
            endcase
            state_in = S_SFT_WR;
         end
         S_SFT_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = {col, 2'd3};
            cmd.wr_src  = WR_ACC;
            if (col == 2'd2) begin
               state_in = S_IDLE;
            end else begin
               cnt_in   = cnt_ff + 4'd1;
               state_in = S_SFT_RD;
            end
         end
         S_ROT_RD: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_addr_a = {row_a, col};
            cmd.rd_addr_b = {row_b, col};
            state_in      = S_ROT_M0;
         end
         S_ROT_M0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_chk = 1'b1;
            cmd.mul_a   = OPN_COS;
            cmd.mul_b   = OPN_RDA;
            state_in    = S_ROT_M1;
         end
         S_ROT_M1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_chk = 1'b1;
            cmd.mul_a   = OPN_SIN;
            cmd.mul_b   = OPN_RDB;
            cmd.t_load  = 1'b1;
            state_in    = S_ROT_M2;
         end
         S_ROT_M2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_chk = 1'b1;
            cmd.mul_a   = OPN_SIN;
            cmd.mul_b   = OPN_RDA;
            cmd.acc_op  = ACC_SUB;
            cmd.acc_lhs = LHS_T;
            cmd.acc_rhs = RHS_PROD;
            state_in    = S_ROT_M3;
         end
         S_ROT_M3: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_chk = 1'b1;
            cmd.mul_a   = OPN_COS;
            cmd.mul_b   = OPN_RDB;
            cmd.t_load  = 1'b1;
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = {row_a, col};
            cmd.wr_src  = WR_ACC;
            state_in    = S_ROT_A1;
         end
         S_ROT_A1: begin
            cmd.acc_op  = ACC_ADD;
            cmd.acc_lhs = LHS_T;
            cmd.acc_rhs = RHS_PROD;
            state_in    = S_ROT_W1;
         end
         S_ROT_W1: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = {row_b, col};
            cmd.wr_src  = WR_ACC;
            if (col == 2'd3) begin
               cnt_in   = '0;
               state_in = (view_ff && !pair_ff) ? S_VW_XSET : S_IDLE;
            end else begin
               cnt_in   = cnt_ff + 4'd1;
               state_in = S_ROT_RD;
            end
         end
         S_TR_RD0: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_addr_a = {col, 2'd0};
            cmd.rd_addr_b = {col, 2'd0};
            state_in      = S_TR_MR1;
         end
         S_TR_MR1: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_chk   = 1'b1;
            cmd.mul_a     = OPN_RDA;
            cmd.mul_b     = OPN_PX;
            cmd.rd_en     = 1'b1;
            cmd.rd_addr_a = {col, 2'd1};
            cmd.rd_addr_b = {col, 2'd1};
            state_in      = S_TR_MR2;
         end
         S_TR_MR2: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_chk   = 1'b1;
            cmd.mul_a     = OPN_RDA;
            cmd.mul_b     = OPN_PY;
            cmd.rd_en     = 1'b1;
            cmd.rd_addr_a = {col, 2'd2};
            cmd.rd_addr_b = {col, 2'd2};
            cmd.t_load    = 1'b1;
            state_in      = S_TR_MR3;
         end
         S_TR_MR3: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_chk   = 1'b1;
            cmd.mul_a     = OPN_RDA;
            cmd.mul_b     = OPN_PZ;
            cmd.rd_en     = 1'b1;
            cmd.rd_addr_a = {col, 2'd3};
            cmd.rd_addr_b = {col, 2'd3};
            cmd.acc_op    = ACC_ADD;
            cmd.acc_lhs   = LHS_T;
            cmd.acc_rhs   = RHS_PROD;
            state_in      = S_TR_A2;
         end
         S_TR_A2: begin
            cmd.acc_op  = ACC_ADD;
            cmd.acc_lhs = LHS_ACC;
            cmd.acc_rhs = RHS_PROD;
            state_in    = S_TR_A3;
         end
         S_TR_A3: begin
            cmd.acc_op   = ACC_ADD;
            cmd.acc_lhs  = LHS_ACC;
            cmd.acc_rhs  = RHS_RDA;
            cmd.out_load = 1'b1;
            cmd.out_row  = col;
            if (col == 2'd2) begin
               state_in = S_TR_OUT;
            end else begin
               cnt_in   = cnt_ff + 4'd1;
               state_in = S_TR_RD0;
            end
         end
         S_TR_OUT: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_VW_SQX: begin
            cmd.mul_en = 1'b1;
            cmd.mul_a  = OPN_PX;
            cmd.mul_b  = OPN_PX;
            state_in   = S_VW_SQY;
         end
         S_VW_SQY: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_a    = OPN_PY;
            cmd.mul_b    = OPN_PY;
            cmd.sq_first = 1'b1;
            state_in     = S_VW_SUM;
         end
         S_VW_SUM: begin
            cmd.sq_add = 1'b1;
            state_in   = S_VW_GO;
         end
         S_VW_GO: begin
            cmd.it_start = 1'b1;
            cmd.it_mode  = IT_SQRT;
            state_in     = S_VW_ROOT;
         end
         S_VW_ROOT: begin
            if (sts.it_done) begin
               cmd.ld   = LD_V;
               state_in = S_VW_CHK;
            end
         end
         S_VW_CHK: begin
            if (sts.v_zero) begin
               state_in = S_VW_XSET;
            end else begin
               cmd.it_start = 1'b1;
               cmd.it_mode  = IT_DIV;
               cmd.div_x    = 1'b0;
               state_in     = S_VW_DIVY;
            end
         end
         S_VW_DIVY: begin
            if (sts.it_done) begin
               cmd.ld       = LD_COS_Q;
               cmd.it_start = 1'b1;
               cmd.it_mode  = IT_DIV;
               cmd.div_x    = 1'b1;
               state_in     = S_VW_DIVX;
            end
         end
         S_VW_DIVX: begin
            cmd.div_x = 1'b1;
            if (sts.it_done) begin
               cmd.ld   = LD_SIN_Q;
               pair_in  = 1'b0;
               cnt_in   = '0;
               state_in = S_ROT_RD;
            end
         end
         S_VW_XSET: begin
            cmd.ld   = LD_XROT;
            pair_in  = 1'b1;
            cnt_in   = '0;
            state_in = S_ROT_RD;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ----- sv/affine_transform_3d_engine.sv -----
`timescale 1ns / 1ps
// Affine transform engine, Q16.16: holds rows 0..2 of a 4x4 matrix, updates it per request
// and maps points through it. One request is worked at a time by a controller driving a
// datapath with one shared multiplier. A view direction request takes a square root and two
// divides at one bit per cycle, then two rotations; when the horizontal length is zero it
// skips the divides and the z rotation.
// The matrix resets to identity at once.
// Overflows saturate and set the saturated flag of the next result, which clears it.
module affine_transform_3d_engine
   import afx_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   afx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.operation),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   afx_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- tb/sv/tb_affine_transform_3d_engine.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the Q16.16 affine transform engine: matrix set-up requests and
// point transforms, predicted in fixed point and compared per field. Depends on afx_pkg and
// affine_transform_3d_engine.
module tb_affine_transform_3d_engine;
   import afx_pkg::*;

   localparam int FRAC = 16;
   localparam longint ONE_Q = 64'sd1 << FRAC;
   localparam longint W_MAX = 64'sd2147483647;
   localparam longint W_MIN = -64'sd2147483648;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   affine_transform_3d_engine dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   longint  mat_q[12];
   bit      sticky_clip;
   bit      clip_flag;
   rsp_type point_q[$];
   int      fail_count = 0;
   int      requests_sent = 0;
   int      points_checked = 0;
   bit      idle_on = 1'b1;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("tb: failure");
      $finish;
   end

   function automatic longint sat_w(longint v);
      if (v > W_MAX) begin
         clip_flag = 1'b1;
         return W_MAX;
      end
      if (v < W_MIN) begin
         clip_flag = 1'b1;
         return W_MIN;
      end
      return v;
   endfunction

   function automatic longint mul_q(longint a, longint b);
      return sat_w((a * b) >>> FRAC);
   endfunction

   function automatic longint div_q(longint n, longint d);
      longint mag;
      longint quo;
      mag = (n < 0) ? -n : n;
      quo = (mag << FRAC) / d;
      return sat_w((n < 0) ? -quo : quo);
   endfunction

   function automatic longint unsigned root_floor(longint unsigned x);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
         t = r | (64'd1 << i);
         if (t * t <= x) r = t;
      end
      return r;
   endfunction

   function automatic void rotate_pair(int ra, int rb, longint c, longint s);
      longint a;
      longint b;
      for (int j = 0; j < 4; j++) begin
         a = mat_q[ra*4+j];
         b = mat_q[rb*4+j];
         mat_q[ra*4+j] = sat_w(mul_q(c, a) - mul_q(s, b));
         mat_q[rb*4+j] = sat_w(mul_q(s, a) + mul_q(c, b));
      end
   endfunction

   function automatic void load_identity();
      for (int i = 0; i < 12; i++) mat_q[i] = (i % 5 == 0) ? ONE_Q : 0;
   endfunction

   function automatic bit transform_step(req_type r, output rsp_type o);
      longint x;
      longint y;
      longint z;
      longint v;
      longint acc;
      longint unsigned mx;
      longint unsigned my;
      longint res[3];
      x = longint'(r.x_coord);
      y = longint'(r.y_coord);
      z = longint'(r.z_coord);
      clip_flag = 1'b0;
      o = '0;
      case (r.operation)
         OP_IDENTITY: load_identity();
         OP_SCALE: for (int i = 0; i < 12; i++)
            mat_q[i] = mul_q(mat_q[i], longint'(r.scale_factor));
         OP_SHIFT: begin
            mat_q[3]  = sat_w(mat_q[3] - x);
            mat_q[7]  = sat_w(mat_q[7] - y);
            mat_q[11] = sat_w(mat_q[11] - z);
         end
         OP_ROT_X: rotate_pair(1, 2, longint'(r.cos_value), longint'(r.sin_value));
         OP_ROT_Z: rotate_pair(0, 1, longint'(r.cos_value), longint'(r.sin_value));
         OP_VIEW: begin
            mx = (x < 0) ? -x : x;
            my = (y < 0) ? -y : y;
            v = sat_w(longint'(root_floor(mx * mx + my * my)));
            if (v != 0) rotate_pair(0, 1, sat_w(-div_q(y, v)), sat_w(-div_q(x, v)));
            rotate_pair(1, 2, z, -v);
         end
         OP_TRANSFORM: begin
            for (int i = 0; i < 3; i++) begin
               acc = sat_w(mul_q(mat_q[i*4], x) + mul_q(mat_q[i*4+1], y));
               acc = sat_w(acc + mul_q(mat_q[i*4+2], z));
               res[i] = sat_w(acc + mat_q[i*4+3]);
            end
            o.out_x = word_type'(res[0]);
            o.out_y = word_type'(res[1]);
            o.out_z = word_type'(res[2]);
            o.saturated = sticky_clip | clip_flag;
            sticky_clip = 1'b0;
            return 1'b1;
         end
         default: ;
      endcase
      if (clip_flag) sticky_clip = 1'b1;
      return 1'b0;
   endfunction

   task automatic send_request(req_type r);
      rsp_type o;
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (transform_step(r, o)) point_q.push_back(o);
      requests_sent++;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   task automatic stop_requests();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type make_req(op_type op, longint sf, longint c, longint s,
                                        longint x, longint y, longint z);
      req_type r;
      r.operation = op;
      r.scale_factor = word_type'(sf);
      r.cos_value = word_type'(c);
      r.sin_value = word_type'(s);
      r.x_coord = word_type'(x);
      r.y_coord = word_type'(y);
      r.z_coord = word_type'(z);
      return r;
   endfunction

   function automatic req_type noise_req();
      req_type r;
      r.operation = 3'($urandom_range(0, 7));
      r.scale_factor = $urandom;
      r.cos_value = $urandom;
      r.sin_value = $urandom;
      r.x_coord = $urandom;
      r.y_coord = $urandom;
      r.z_coord = $urandom;
      return r;
   endfunction

   function automatic longint rand_coord();
      return longint'($urandom_range(0, 2097152)) - 1048576;
   endfunction

   task automatic send_point();
      send_request(make_req(OP_TRANSFORM, 0, 0, 0, rand_coord(), rand_coord(), rand_coord()));
   endtask

   task automatic drain_points();
      stop_requests();
      while (point_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_matrix_extremes();
      send_point();
      send_request(make_req(OP_TRANSFORM, 0, 0, 0, W_MAX, W_MIN, W_MAX));
      send_request(make_req(OP_SCALE, W_MAX, 0, 0, 0, 0, 0));
      send_request(make_req(OP_TRANSFORM, 0, 0, 0, W_MIN, W_MAX, -1));
      send_request(make_req(OP_SCALE, W_MIN, 0, 0, 0, 0, 0));
      send_point();
      send_request(make_req(OP_IDENTITY, 0, 0, 0, 0, 0, 0));
      send_request(make_req(OP_SHIFT, 0, 0, 0, W_MIN, W_MAX, 0));
      send_request(make_req(OP_SHIFT, 0, 0, 0, W_MIN, W_MIN, 1));
      send_point();
      send_request(make_req(OP_IDENTITY, 0, 0, 0, 0, 0, 0));
      send_request(make_req(OP_ROT_X, 0, 0, W_MIN, 0, 0, 0));
      send_request(make_req(OP_ROT_Z, 0, W_MAX, W_MAX, 0, 0, 0));
      send_point();
      send_request(make_req(OP_NONE, W_MAX, W_MIN, -1, -1, -1, -1));
      send_point();
   endtask

   task automatic test_view_cases();
      send_request(make_req(OP_IDENTITY, 0, 0, 0, 0, 0, 0));
      // zero horizontal length skips the z rotation
      send_request(make_req(OP_VIEW, 0, 0, 0, 0, 0, ONE_Q));
      send_point();
      send_request(make_req(OP_IDENTITY, 0, 0, 0, 0, 0, 0));
      send_request(make_req(OP_VIEW, 0, 0, 0, 37837, 37837, 37837));
      send_point();
      send_request(make_req(OP_VIEW, 0, 0, 0, W_MIN, W_MIN, W_MIN));
      send_point();
      send_request(make_req(OP_VIEW, 0, 0, 0, 1, W_MAX, 0));
      send_point();
   endtask

   task automatic test_random_mix(int count);
      real ang;
      longint c;
      longint s;
      for (int n = 0; n < count; n++) begin
         ang = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
         c = longint'($rtoi($cos(ang) * 65536.0));
         s = longint'($rtoi($sin(ang) * 65536.0));
         if (n % 40 == 0) begin
            send_request(make_req(OP_IDENTITY, 0, 0, 0, 0, 0, 0));
         end else if ($urandom_range(0, 19) == 0) begin
            send_request(noise_req());
         end else if ($urandom_range(0, 9) < 7) begin
            send_point();
         end else begin
            case ($urandom_range(0, 4))
               0: send_request(make_req(OP_SCALE, longint'($urandom_range(32768, 131072)),
                                        0, 0, 0, 0, 0));
               1: send_request(make_req(OP_SHIFT, 0, 0, 0, rand_coord(), rand_coord(),
                                        rand_coord()));
               2: send_request(make_req(OP_ROT_X, 0, c, s, 0, 0, 0));
               3: send_request(make_req(OP_ROT_Z, 0, c, s, 0, 0, 0));
               default: begin
                  if ($urandom_range(0, 4) == 0)
                     send_request(make_req(OP_VIEW, 0, 0, 0, 0, 0, c));
                  else
                     send_request(make_req(OP_VIEW, 0, 0, 0, c, s, rand_coord() >>> 4));
               end
            endcase
         end
         if (n == count / 2) drain_points();
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (point_q.size() == 0) begin
            $error("unexpected point out: %h", rsp_data);
            fail_count++;
         end else begin
            want = point_q.pop_front();
            points_checked++;
            if (rsp_data.out_x !== want.out_x) begin
               $error("out_x expected %h got %h", want.out_x, rsp_data.out_x);
               fail_count++;
            end
            if (rsp_data.out_y !== want.out_y) begin
               $error("out_y expected %h got %h", want.out_y, rsp_data.out_y);
               fail_count++;
            end
            if (rsp_data.out_z !== want.out_z) begin
               $error("out_z expected %h got %h", want.out_z, rsp_data.out_z);
               fail_count++;
            end
            if (rsp_data.saturated !== want.saturated) begin
               $error("saturated expected %b got %b", want.saturated, rsp_data.saturated);
               fail_count++;
            end
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      load_identity();
      sticky_clip = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_matrix_extremes();
      test_view_cases();
      test_random_mix(1400);
      drain_points();
      idle_on = 1'b0;
      test_random_mix(180);
      drain_points();
      repeat (250) @(posedge clock);
      $display("covered %0d requests, %0d points checked, all operations and view edge cases",
               requests_sent, points_checked);
      if (fail_count == 0 && point_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/afx_pkg.sv
sv/afx_iter.sv
sv/afx_dp.sv
sv/afx_ctrl.sv
sv/affine_transform_3d_engine.sv
tb/sv/tb_affine_transform_3d_engine.sv
